// ===== hw/rtl/eabv_pkg.sv =====
// eabv_pkg: shared types, constants and rounding helpers for the euler-angle basis block
// no dependencies
package eabv_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int Q = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) as a fraction of one turn, 2^32 per turn
    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;   1: t = 32'd316933406;
            2: t = 32'd167458907;   3: t = 32'd85004756;
            4: t = 32'd42667331;    5: t = 32'd21354465;
            6: t = 32'd10680350;    7: t = 32'd5340245;
            8: t = 32'd2670163;     9: t = 32'd1335087;
            10: t = 32'd667544;     11: t = 32'd333772;
            12: t = 32'd166886;     13: t = 32'd83443;
            14: t = 32'd41722;      15: t = 32'd20861;
            16: t = 32'd10430;      17: t = 32'd5215;
            18: t = 32'd2608;       19: t = 32'd1304;
            20: t = 32'd652;        21: t = 32'd326;
            22: t = 32'd163;        23: t = 32'd81;
            24: t = 32'd41;         25: t = 32'd20;
            26: t = 32'd10;         27: t = 32'd5;
            28: t = 32'd3;          29: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

    // sine and cosine of one angle, Q30
    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } sincos_t;

    // product of two Q30 values, rounded half away from zero
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic [63:0] m;
        logic [63:0] r;
        p = 64'(a) * 64'(b);
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + 64'(1 << (Q - 1))) >> Q;
        return p[63] ? -32'(r) : 32'(r);
    endfunction

endpackage

// ===== hw/rtl/eabv_sincos.sv =====
// eabv_sincos: pipelined phase conversion, quadrant fold and cordic for one angle
// depends on eabv_pkg
module eabv_sincos #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic signed [15:0]   angle,
    output eabv_pkg::sincos_t    result
);
    localparam int STEPS = eabv_pkg::CORDIC_STEPS;

    // phase = round(angle * 2^32 / (360 * 2^ANGLE_FRAC_BITS)) mod 2^32
    //       = floor((angle * 2^K + 22) / 45), K = 29 - ANGLE_FRAC_BITS
    // angle is offset by 2^15 so every term stays non-negative
    localparam int K = 29 - ANGLE_FRAC_BITS;
    localparam longint QK = (longint'(1) << K) / 45;
    localparam longint RK = (longint'(1) << K) % 45;
    localparam longint QO = (longint'(1) << (K + 15)) / 45;
    localparam longint RO = (longint'(1) << (K + 15)) % 45;
    localparam int RSH = 28;
    localparam longint RECIP = ((longint'(1) << RSH) + 44) / 45;

    // stage a: offset angle, split into whole multiples of 45 and a remainder term
    logic [15:0] au;
    logic [39:0] aq_full;
    logic [31:0] aq_reg;
    logic [21:0] m_next, m_reg;
    assign au = {~angle[15], angle[14:0]};
    assign aq_full = 40'(au) * 40'(QK);
    assign m_next = 22'(au) * 22'(RK) + 22'(67 - RO);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aq_reg <= aq_full[31:0];
            m_reg <= m_next;
        end
    end

    // stage b: remainder term over 45 by reciprocal multiply, exact for m < 2^22
    logic [44:0] mq;
    logic [31:0] phase_reg;
    assign mq = 45'(m_reg) * 45'(RECIP);
    always_ff @(posedge clk)
    begin
        if (en)
            phase_reg <= aq_reg + 32'(mq >> RSH) - 32'(QO + 1);
    end

    // cordic stages
    logic signed [33:0] x_reg [STEPS+1];
    logic signed [33:0] y_reg [STEPS+1];
    logic signed [33:0] z_reg [STEPS+1];
    logic [1:0] q_reg [STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= eabv_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= 34'({2'b00, phase_reg[29:0]});
            q_reg[0] <= phase_reg[31:30];
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [33:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[i+1] <= q_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - 34'(eabv_pkg::atan_turns(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + 34'(eabv_pkg::atan_turns(i));
                end
            end
        end
    end

    // clamp and fold by quadrant
    localparam logic signed [33:0] ONE = 34'sd1 << eabv_pkg::Q;
    logic signed [31:0] cs, sn;
    always_comb
    begin
        cs = (x_reg[STEPS] > ONE) ? 32'(ONE) : (x_reg[STEPS] < -ONE) ? 32'(-ONE)
             : 32'(x_reg[STEPS]);
        sn = (y_reg[STEPS] > ONE) ? 32'(ONE) : (y_reg[STEPS] < -ONE) ? 32'(-ONE)
             : 32'(y_reg[STEPS]);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result <= '0;
        else if (en)
        begin
            case (q_reg[STEPS])
                2'd0: result <= '{s: sn, c: cs};
                2'd1: result <= '{s: cs, c: -sn};
                2'd2: result <= '{s: -sn, c: -cs};
                default: result <= '{s: -cs, c: sn};
            endcase
        end
    end
endmodule

// ===== hw/rtl/eabv_combine.sv =====
// eabv_combine: pipelined products forming the nine basis components
// depends on eabv_pkg
module eabv_combine #(
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                en,
    input  logic                negate_side_vector,
    input  eabv_pkg::sincos_t   yaw,
    input  eabv_pkg::sincos_t   pitch,
    input  eabv_pkg::sincos_t   roll,
    output logic signed [15:0]  comp [9]
);
    // stage 1: first products
    logic signed [31:0] cpcy_reg, cpsy_reg, nsp_reg, crsy_reg, crcy_reg, srcp_reg;
    logic signed [31:0] srsy_reg, srcy_reg, crcp_reg, srsp_reg, crsp_reg;
    logic signed [31:0] sy1_reg, cy1_reg;
    logic neg1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpcy_reg <= eabv_pkg::mulq(pitch.c, yaw.c);
            cpsy_reg <= eabv_pkg::mulq(pitch.c, yaw.s);
            nsp_reg  <= -pitch.s;
            crsy_reg <= eabv_pkg::mulq(roll.c, yaw.s);
            crcy_reg <= eabv_pkg::mulq(roll.c, yaw.c);
            srcp_reg <= eabv_pkg::mulq(roll.s, pitch.c);
            srsy_reg <= eabv_pkg::mulq(roll.s, yaw.s);
            srcy_reg <= eabv_pkg::mulq(roll.s, yaw.c);
            crcp_reg <= eabv_pkg::mulq(roll.c, pitch.c);
            srsp_reg <= eabv_pkg::mulq(roll.s, pitch.s);
            crsp_reg <= eabv_pkg::mulq(roll.c, pitch.s);
            sy1_reg  <= yaw.s;
            cy1_reg  <= yaw.c;
            neg1_reg <= negate_side_vector;
        end
    end

    // stage 2: second products and sums
    logic signed [33:0] v_reg [9];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0] <= 34'(cpcy_reg);
            v_reg[1] <= 34'(cpsy_reg);
            v_reg[2] <= 34'(nsp_reg);
            v_reg[3] <= neg1_reg ?
                (34'(eabv_pkg::mulq(srsp_reg, cy1_reg)) - 34'(crsy_reg)) :
                (34'(crsy_reg) - 34'(eabv_pkg::mulq(srsp_reg, cy1_reg)));
            v_reg[4] <= neg1_reg ?
                (34'(eabv_pkg::mulq(srsp_reg, sy1_reg)) + 34'(crcy_reg)) :
                (-34'(eabv_pkg::mulq(srsp_reg, sy1_reg)) - 34'(crcy_reg));
            v_reg[5] <= neg1_reg ? 34'(srcp_reg) : -34'(srcp_reg);
            v_reg[6] <= 34'(eabv_pkg::mulq(crsp_reg, cy1_reg)) + 34'(srsy_reg);
            v_reg[7] <= 34'(eabv_pkg::mulq(crsp_reg, sy1_reg)) - 34'(srcy_reg);
            v_reg[8] <= 34'(crcp_reg);
        end
    end

    // stage 3: round to output format and saturate
    localparam int SH = eabv_pkg::Q - OUT_FRAC_BITS;
    localparam logic signed [33:0] OONE = 34'sd1 <<< OUT_FRAC_BITS;
    for (genvar k = 0; k < 9; k++)
    begin : g_out
        logic [33:0] m, r;
        logic signed [33:0] o;
        always_comb
        begin
            m = v_reg[k][33] ? 34'(-v_reg[k]) : 34'(v_reg[k]);
            r = (SH > 0) ? ((m + (34'd1 << (SH - 1))) >> SH) : m;
            o = v_reg[k][33] ? -34'(r) : 34'(r);
            if (o > OONE)
                o = OONE;
            if (o < -OONE)
                o = -OONE;
        end
        always_ff @(posedge clk)
        begin
            if (en)
                comp[k] <= o[15:0];
        end
    end
endmodule

// ===== hw/rtl/euler_angles_to_basis_vectors.sv =====
// euler_angles_to_basis_vectors: yaw/pitch/roll in degrees to forward, side, up vectors
// pipeline stages: phase split, phase scale, cordic load, 30 cordic stages, fold,
// three combine stages
// throughput one request per cycle; a stall at the output freezes the whole pipeline
// rst_n asynchronously clears the valid bits and the side-negate register
// depends on eabv_pkg, eabv_sincos, eabv_combine
module euler_angles_to_basis_vectors #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] yaw_deg,
    input  logic signed [15:0] pitch_deg,
    input  logic signed [15:0] roll_deg,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] forward_x,
    output logic signed [15:0] forward_y,
    output logic signed [15:0] forward_z,
    output logic signed [15:0] side_x,
    output logic signed [15:0] side_y,
    output logic signed [15:0] side_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z
);
    // stage count: 2 front + cordic load + 30 cordic + fold + 3 combine
    localparam int DEPTH = 2 + 1 + eabv_pkg::CORDIC_STEPS + 1 + 3;

    logic side_neg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_neg_reg <= 1'b0;
        else if (cfg_we)
            side_neg_reg <= cfg_wdata;
    end

    // whole pipeline advances together unless the last slot holds an untaken request
    logic en;
    logic [DEPTH-1:0] vld_reg;
    assign en = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    eabv_pkg::sincos_t yaw_sc, pitch_sc, roll_sc;

    eabv_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(yaw_deg), .result(yaw_sc));
    eabv_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(pitch_deg), .result(pitch_sc));
    eabv_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
        .clk(clk), .rst_n(rst_n), .en(en), .angle(roll_deg), .result(roll_sc));

    // user keeps config static while requests are in flight; block does not enforce it
    logic signed [15:0] comp [9];
    eabv_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_combine (
        .clk(clk), .en(en), .negate_side_vector(side_neg_reg),
        .yaw(yaw_sc), .pitch(pitch_sc), .roll(roll_sc), .comp(comp));

    assign forward_x = comp[0];
    assign forward_y = comp[1];
    assign forward_z = comp[2];
    assign side_x    = comp[3];
    assign side_y    = comp[4];
    assign side_z    = comp[5];
    assign up_x      = comp[6];
    assign up_y      = comp[7];
    assign up_z      = comp[8];
endmodule
